// File: hw/rtl/cubic_bezier_uniform_tessellator_unit_assert.svh
// ---------------------------------------------------------------------------
// cubic bezier tessellator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_UNIFORM_TESSELLATOR_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_UNIFORM_TESSELLATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbt check failed");
`define CBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbt check failed");
`else
`define CBT_ASSERT_IMP(lbl, ante, cons)
`define CBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/cbt_pkg.sv
// ---------------------------------------------------------------------------
// cbt_pkg
// shared constants and control types of the bezier tessellator
// ---------------------------------------------------------------------------
package cbt_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int NUM_COORDS = 12;
  localparam int LVL_BITS   = 2;
  localparam int SEG_BITS   = 2;

  localparam logic [SEG_BITS-1:0] SEG_FIRST = 2'd0;
  localparam logic [SEG_BITS-1:0] SEG_MID   = 2'd1;
  localparam logic [SEG_BITS-1:0] SEG_LAST  = 2'd2;

  typedef struct packed {
    logic                load;
    logic                split;
    logic                pop;
    logic                emit;
    logic                last;
    logic [SEG_BITS-1:0] seg;
    logic [LVL_BITS-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/cbt_in_if.sv
// ---------------------------------------------------------------------------
// cbt_in_if
// input channel: four 3d control points per item
// ---------------------------------------------------------------------------
interface cbt_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z;
  logic signed [COORD_BITS-1:0] p3_x, p3_y, p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

// File: hw/rtl/cbt_out_if.sv
// ---------------------------------------------------------------------------
// cbt_out_if
// result channel: one line segment per item
// ---------------------------------------------------------------------------
interface cbt_out_if import cbt_pkg::*; #(
  parameter int COORD_BITS = 16
);
  localparam int OW = COORD_BITS + FRAC_BITS;

  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] start_x, start_y, start_z;
  logic signed [OW-1:0] end_x, end_y, end_z;
  logic                 last_segment;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
    output ready
  );
endinterface

// File: hw/rtl/cbt_datapath.sv
// ---------------------------------------------------------------------------
// cbt_datapath
// curve register, midpoint splitter, right-half stack and output register
// ---------------------------------------------------------------------------
module cbt_datapath import cbt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int MAX_LEVELS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  cbt_in_if.sink        in_ch,
  cbt_out_if.source     out_ch,
  input  cmd_t          cmd,
  output status_t       st
);
  localparam int OW     = COORD_BITS + FRAC_BITS;
  localparam int SW     = OW + 3;
  localparam int LVL_IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic signed [OW-1:0] cur_r [NUM_COORDS];
  logic signed [OW-1:0] stk_r [MAX_LEVELS][NUM_COORDS];
  logic signed [OW-1:0] left  [NUM_COORDS];
  logic signed [OW-1:0] right [NUM_COORDS];
  logic signed [OW-1:0] in_cur [NUM_COORDS];

  logic signed [OW-1:0] start_r [3];
  logic signed [OW-1:0] end_r   [3];
  logic                 last_r;
  logic                 out_valid_r;
  logic signed [OW-1:0] seg_start [3];
  logic signed [OW-1:0] seg_end   [3];

  logic [LVL_IW-1:0] row;

  assign row = cmd.idx[LVL_IW-1:0];

  assign in_cur[0]  = $signed({in_ch.p0_x, {FRAC_BITS{1'b0}}});
  assign in_cur[1]  = $signed({in_ch.p0_y, {FRAC_BITS{1'b0}}});
  assign in_cur[2]  = $signed({in_ch.p0_z, {FRAC_BITS{1'b0}}});
  assign in_cur[3]  = $signed({in_ch.p1_x, {FRAC_BITS{1'b0}}});
  assign in_cur[4]  = $signed({in_ch.p1_y, {FRAC_BITS{1'b0}}});
  assign in_cur[5]  = $signed({in_ch.p1_z, {FRAC_BITS{1'b0}}});
  assign in_cur[6]  = $signed({in_ch.p2_x, {FRAC_BITS{1'b0}}});
  assign in_cur[7]  = $signed({in_ch.p2_y, {FRAC_BITS{1'b0}}});
  assign in_cur[8]  = $signed({in_ch.p2_z, {FRAC_BITS{1'b0}}});
  assign in_cur[9]  = $signed({in_ch.p3_x, {FRAC_BITS{1'b0}}});
  assign in_cur[10] = $signed({in_ch.p3_y, {FRAC_BITS{1'b0}}});
  assign in_cur[11] = $signed({in_ch.p3_z, {FRAC_BITS{1'b0}}});

  // de casteljau midpoints, three guard bits so the sums cannot overflow; the shifts floor
  always_comb begin
    logic signed [SW-1:0] a, b, d, e;
    logic signed [SW-1:0] s1, s2, s3, r1, r2;
    for (int k = 0; k < 3; k++) begin
      a  = SW'(cur_r[k]);
      b  = SW'(cur_r[3 + k]);
      d  = SW'(cur_r[6 + k]);
      e  = SW'(cur_r[9 + k]);
      s1 = (a + b) >>> 1;
      s2 = (a + (b <<< 1) + d) >>> 2;
      s3 = (a + (b <<< 1) + b + (d <<< 1) + d + e) >>> 3;
      r1 = (b + (d <<< 1) + e) >>> 2;
      r2 = (d + e) >>> 1;
      left[k]      = cur_r[k];
      left[3 + k]  = OW'(s1);
      left[6 + k]  = OW'(s2);
      left[9 + k]  = OW'(s3);
      right[k]     = OW'(s3);
      right[3 + k] = OW'(r1);
      right[6 + k] = OW'(r2);
      right[9 + k] = cur_r[9 + k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_cur;
    end else if (cmd.split) begin
      cur_r      <= left;
      stk_r[row] <= right;
    end else if (cmd.pop) begin
      cur_r <= stk_r[row];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (cmd.seg)
        SEG_FIRST: begin
          seg_start[k] = cur_r[k];
          seg_end[k]   = cur_r[3 + k];
        end
        SEG_MID: begin
          seg_start[k] = cur_r[3 + k];
          seg_end[k]   = cur_r[6 + k];
        end
        SEG_LAST: begin
          seg_start[k] = cur_r[6 + k];
          seg_end[k]   = cur_r[9 + k];
        end
        default: begin
          seg_start[k] = cur_r[k];
          seg_end[k]   = cur_r[3 + k];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      start_r <= seg_start;
      end_r   <= seg_end;
      last_r  <= cmd.last;
    end
  end

  assign st.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.start_x      = start_r[0];
  assign out_ch.start_y      = start_r[1];
  assign out_ch.start_z      = start_r[2];
  assign out_ch.end_x        = end_r[0];
  assign out_ch.end_y        = end_r[1];
  assign out_ch.end_z        = end_r[2];
  assign out_ch.last_segment = last_r;

endmodule

// File: hw/rtl/cbt_ctrl.sv
// ---------------------------------------------------------------------------
// cbt_ctrl
// depth-first traversal sequencer and level register
// ---------------------------------------------------------------------------
`include "cubic_bezier_uniform_tessellator_unit_assert.svh"

module cbt_ctrl import cbt_pkg::*; #(
  parameter int MAX_LEVELS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  status_t    st,
  output cmd_t       cmd
);
  localparam int DW = $clog2(MAX_LEVELS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [DW-1:0]         depth_r, depth_nxt;
  logic [MAX_LEVELS-1:0] path_r, path_nxt;
  logic [SEG_BITS-1:0]   seg_r, seg_nxt;
  logic [2:0]            lvl_r;
  logic [DW-1:0]         lvl_eff;
  logic                  found;
  logic [DW-1:0]         pop_d;

  assign lvl_eff = (lvl_r > 3'(MAX_LEVELS)) ? DW'(MAX_LEVELS) : DW'(lvl_r);

  // deepest level whose right half is still pending
  always_comb begin
    found = 1'b0;
    pop_d = '0;
    for (int d = 0; d < MAX_LEVELS; d++) begin
      if (DW'(d) < depth_r && !path_r[d]) begin
        found = 1'b1;
        pop_d = DW'(d);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    path_nxt  = path_r;
    seg_nxt   = seg_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          depth_nxt = '0;
          path_nxt  = '0;
          seg_nxt   = SEG_FIRST;
          state_nxt = (lvl_eff != '0) ? ST_SPLIT : ST_EMIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        cmd.idx   = LVL_BITS'(depth_r);
        for (int d = 0; d < MAX_LEVELS; d++) begin
          if (DW'(d) == depth_r) path_nxt[d] = 1'b0;
        end
        depth_nxt = depth_r + 1'b1;
        state_nxt = (depth_r + 1'b1 == lvl_eff) ? ST_EMIT : ST_SPLIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.seg  = seg_r;
          cmd.last = (seg_r == SEG_LAST) && !found;
          if (seg_r == SEG_LAST) begin
            seg_nxt = SEG_FIRST;
            if (!found) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.pop = 1'b1;
              cmd.idx = LVL_BITS'(pop_d);
              for (int d = 0; d < MAX_LEVELS; d++) begin
                if (DW'(d) == pop_d) path_nxt[d] = 1'b1;
              end
              depth_nxt = pop_d + 1'b1;
              state_nxt = (pop_d + 1'b1 == lvl_eff) ? ST_EMIT : ST_SPLIT;
            end
          end else begin
            seg_nxt = seg_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      depth_r <= '0;
      path_r  <= '0;
      seg_r   <= SEG_FIRST;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      path_r  <= path_nxt;
      seg_r   <= seg_nxt;
      if (cfg_we) lvl_r <= cfg_data;
    end
  end

  `CBT_ASSERT_IMP(a_split_below_levels, state_r == ST_SPLIT, depth_r < lvl_eff)
  `CBT_ASSERT_IMP(a_emit_at_leaf, state_r == ST_EMIT, depth_r == lvl_eff)
  `CBT_ASSERT_NEXT(a_last_ends_item, cmd.emit && cmd.last, state_r == ST_IDLE)
  `CBT_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready, state_r != ST_IDLE)

endmodule

// File: hw/rtl/cubic_bezier_uniform_tessellator_unit.sv
// ---------------------------------------------------------------------------
// cubic_bezier_uniform_tessellator_unit
// uniform de casteljau tessellation of one cubic bezier curve per item
// ---------------------------------------------------------------------------
//  channel  direction  carries
//  in_ch    sink       four control points, COORD_BITS each
//  out_ch   source     one segment, COORD_BITS+12 each, last flag
//  cfg      write      subdivision levels, 3 bits
//
//  an item with L levels emits 3*2^L segments after acceptance: 2^L - 1
//  splits by the single midpoint unit, with each segment passing through
//  the one output register
//  the next item is accepted once the last segment sits in the output register
//  a stalled out_ch holds the segment and pauses the sequencer
//  rst_n is synchronous, active low; curve and stack storage are not cleared
// ---------------------------------------------------------------------------
module cubic_bezier_uniform_tessellator_unit import cbt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int MAX_LEVELS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cbt_in_if.sink     in_ch,
  cbt_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);
  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  cbt_ctrl #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cbt_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule
